// File: rtl/core/glyph_quad_layout_core_defines.svh
// Assertion macros shared by the glyph quad layout RTL.
`ifndef GLYPH_QUAD_LAYOUT_CORE_DEFINES_SVH
`define GLYPH_QUAD_LAYOUT_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GQL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GQL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gql_pkg.sv
// Shared types, codes and constants of the glyph quad layout core.
package gql_pkg;

    localparam int unsigned GLYPH_COUNT_DEF = 256;
    localparam int unsigned FRAC_BITS_DEF   = 8;

    localparam int unsigned SCALE_FRAC = 8;   // scale_q8 fraction bits
    localparam int unsigned ADV_SHIFT  = 6;   // advance is in 1/64 pixel
    localparam int unsigned TAB_SHIFT  = 2;   // tab = four space widths
    localparam int unsigned PEN_W      = 32;
    localparam int unsigned PX_W       = 16;
    localparam int unsigned ENTRY_W    = 64;
    localparam int unsigned LINES_W    = 12;
    localparam int unsigned PS_W       = 27;  // (height + gap) * scale

    localparam int unsigned IN_DATA_W  = 88;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 80;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_CHAR  = 2'd2;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_GAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd4;

    typedef enum logic [2:0] {
        OP_START,
        OP_NEWLINE,
        OP_TAB,
        OP_SPACE,
        OP_GLYPH
    } t_op;

    typedef struct packed {
        logic        [9:0]  font_height;
        logic        [7:0]  line_gap;
        logic        [15:0] scale_q8;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        font_height: 10'd16,
        line_gap:    8'd0,
        scale_q8:    16'd256,
        offset_x:    16'sd0,
        offset_y:    16'sd0
    };

    // glyph table entry, advance in the lowest bits
    typedef struct packed {
        logic        [15:0] texture;
        logic        [7:0]  height;
        logic        [7:0]  width;
        logic signed [7:0]  bearing_top;
        logic signed [7:0]  bearing_left;
        logic        [15:0] advance;
    } t_entry;

    // result item, left edge in the lowest bits
    typedef struct packed {
        logic        [15:0] texture;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic signed [15:0] left;
    } t_quad;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        t_op  op;
    } t_dp_ctl;

endpackage

// File: rtl/core/glyph_quad_layout_core.sv
// Top level of the glyph quad layout core: registers, sequencer, glyph table, quad output.
// Load item: written to the glyph table when taken. Start, newline, tab, space: table read with
// multiply, then pen update. Drawn glyph: table read with multiply, pen update, then corner
// rounding into the output register, delayed while the output stays full.
// Reset: pen at the origin, registers at their defaults, glyph table undefined until loaded.
`include "glyph_quad_layout_core_defines.svh"
module glyph_quad_layout_core
    import gql_pkg::*;
#(
    parameter int unsigned GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // char_code, glyph_advance, bearing_left, bearing_top, glyph_width, glyph_height,
    // glyph_texture, line_count, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // quad_left, quad_bottom, quad_right, quad_top, quad_texture
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned AW   = $clog2(GLYPH_COUNT);
    localparam int unsigned WRAP = (GLYPH_COUNT < 256) ? GLYPH_COUNT : 256;
    localparam logic [AW-1:0] SPACE_IDX = AW'(CH_SPACE);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SUM  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // configuration registers
    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [10:0]      pitch_n;
    logic [PS_W-1:0]  r_pitch_scale;

    assign o_cfg_ready = i_rst_n;

    always_comb begin
        n_cfg = r_cfg;
        if (!i_rst_n) begin
            n_cfg = CFG_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FONT_HEIGHT: n_cfg.font_height = i_cfg_data[9:0];
                CFG_LINE_GAP:    n_cfg.line_gap    = i_cfg_data[7:0];
                CFG_SCALE:       n_cfg.scale_q8    = i_cfg_data;
                CFG_OFFSET_X:    n_cfg.offset_x    = $signed(i_cfg_data);
                CFG_OFFSET_Y:    n_cfg.offset_y    = $signed(i_cfg_data);
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // line pitch product follows the register values it will see
    assign pitch_n = 11'(n_cfg.font_height) + 11'(n_cfg.line_gap);

    always_ff @(posedge i_clk) begin
        r_cfg         <= n_cfg;
        r_pitch_scale <= pitch_n * n_cfg.scale_q8;
    end

    // input decode
    logic [1:0]         req;
    logic [7:0]         code;
    logic [8:0]         code9;
    logic [8:0]         idx9;
    logic [AW-1:0]      idx;
    logic [LINES_W-1:0] line_count_in;
    t_entry             entry_in;
    t_op                char_op;

    assign req           = s_axis_tuser[1:0];
    assign code          = s_axis_tdata[7:0];
    assign entry_in      = t_entry'(s_axis_tdata[71:8]);
    assign line_count_in = s_axis_tdata[83:72];
    assign code9         = {1'b0, code};
    assign idx9          = (code9 >= 9'(WRAP)) ? code9 - 9'(WRAP) : code9;
    assign idx           = AW'(idx9);

    always_comb begin
        case (code)
            CH_NEWLINE: char_op = OP_NEWLINE;
            CH_TAB:     char_op = OP_TAB;
            CH_SPACE:   char_op = OP_SPACE;
            default:    char_op = OP_GLYPH;
        endcase
    end

    // sequencer
    t_state             r_state;
    t_state             n_state;
    t_op                r_op;
    t_op                n_op;
    logic [LINES_W-1:0] r_lines;
    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic               r_out_valid;
    t_quad              r_out_quad;
    t_quad              quad;

    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (r_state == S_OUT) && out_free;
    // next item is taken in the cycle the current one finishes
    assign s_axis_tready = i_rst_n && ((r_state == S_IDLE)
                        || ((r_state == S_SUM) && (r_op != OP_GLYPH))
                        || out_load);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: n_state = S_IDLE;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = (r_op == OP_GLYPH) ? S_OUT : S_IDLE;
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
        if (in_acc) begin
            case (req)
                REQ_START: begin
                    n_state = S_MUL;
                    n_op    = OP_START;
                end
                REQ_CHAR: begin
                    n_state = S_MUL;
                    n_op    = char_op;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_START;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lines <= line_count_in;
        end
    end

    // glyph table; a load is written before any later item reads, so no bypass
    logic [ENTRY_W-1:0] rd_data;
    logic [AW-1:0]      rd_addr;

    assign rd_addr = (code == CH_TAB) ? SPACE_IDX : idx;

    gql_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GLYPH_COUNT)
    ) u_glyph_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && (req == REQ_LOAD)),
        .i_wr_addr (idx),
        .i_wr_data (ENTRY_W'(entry_in)),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    t_dp_ctl dp_ctl;

    assign dp_ctl.mul_en = (r_state == S_MUL);
    assign dp_ctl.sum_en = (r_state == S_SUM);
    assign dp_ctl.op     = r_op;

    gql_pen_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (dp_ctl),
        .i_cfg         (r_cfg),
        .i_pitch_scale (r_pitch_scale),
        .i_entry       (t_entry'(rd_data)),
        .i_line_count  (r_lines),
        .o_quad        (quad)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_quad <= quad;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_quad);

    `GQL_ASSERT_NEXT(a_item_to_mul, in_acc && (req == REQ_START || req == REQ_CHAR), r_state == S_MUL, "start or character item did not enter the multiply step")
    `GQL_ASSERT_NEXT(a_mul_to_sum, r_state == S_MUL, r_state == S_SUM, "multiply step not followed by pen update")
    `GQL_ASSERT_NOW(a_out_glyph_only, r_state == S_OUT, r_op == OP_GLYPH, "output step entered for an item that draws nothing")
    `GQL_ASSERT_NEXT(a_out_waits, (r_state == S_OUT) && !out_free, (r_state == S_OUT) && $stable(r_out_quad), "pending quad lost while output full")

endmodule

// File: rtl/core/gql_ram.sv
// Generic simple dual-port RAM with registered read.
module gql_ram
    import gql_pkg::*;
#(
    parameter  int unsigned WIDTH = ENTRY_W,
    parameter  int unsigned DEPTH = GLYPH_COUNT_DEF,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/gql_pen_unit.sv
// Pen datapath: scale multiplies, pen update and quad corner rounding.
module gql_pen_unit
    import gql_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_ctl            i_ctl,
    input  t_cfg               i_cfg,
    input  logic [PS_W-1:0]    i_pitch_scale,
    input  t_entry             i_entry,
    input  logic [LINES_W-1:0] i_line_count,
    output t_quad              o_quad
);

    localparam int unsigned SHL = (FRAC_BITS >= SCALE_FRAC) ? FRAC_BITS - SCALE_FRAC : 0;
    localparam int unsigned SHR = (FRAC_BITS < SCALE_FRAC) ? SCALE_FRAC - FRAC_BITS : 0;
    localparam int unsigned WW  = 42 + SHL;   // pen-format working width
    localparam int unsigned OW  = WW + 2;     // corner plus size plus offset
    localparam int unsigned HALF_Q8 = 1 << (SCALE_FRAC - 1);

    localparam logic signed [WW-1:0] PEN_MAX = {{(WW-PEN_W+1){1'b0}}, {(PEN_W-1){1'b1}}};
    localparam logic signed [WW-1:0] PEN_MIN = {{(WW-PEN_W+1){1'b1}}, {(PEN_W-1){1'b0}}};
    localparam logic signed [OW-1:0] PX_MAX  = {{(OW-PX_W+1){1'b0}}, {(PX_W-1){1'b1}}};
    localparam logic signed [OW-1:0] PX_MIN  = {{(OW-PX_W+1){1'b1}}, {(PX_W-1){1'b0}}};

    // divide by 2^sh, half away from zero
    function automatic logic signed [WW-1:0] rnd_shr(input logic signed [WW-1:0] v,
                                                     input int unsigned sh);
        logic [WW-1:0] mag;
        logic [WW-1:0] half;
        half = (WW'(1) << sh) >> 1;
        mag  = v[WW-1] ? -v : v;
        mag  = (mag + half) >> sh;
        return v[WW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    // exact Q8.8 product to pen format
    function automatic logic signed [WW-1:0] to_pen(input logic signed [WW-1:0] q8);
        return rnd_shr(q8, SHR) <<< SHL;
    endfunction

    function automatic logic signed [PEN_W-1:0] sat_pen(input logic signed [WW-1:0] v);
        if (v > PEN_MAX) begin
            return PEN_MAX[PEN_W-1:0];
        end else if (v < PEN_MIN) begin
            return PEN_MIN[PEN_W-1:0];
        end
        return v[PEN_W-1:0];
    endfunction

    function automatic logic signed [PX_W-1:0] sat_px(input logic signed [OW-1:0] v);
        if (v > PX_MAX) begin
            return PX_MAX[PX_W-1:0];
        end else if (v < PX_MIN) begin
            return PX_MIN[PX_W-1:0];
        end
        return v[PX_W-1:0];
    endfunction

    // multiply stage operands
    logic        [9:0]  adv_px;
    logic signed [9:0]  dy_px;
    logic signed [16:0] scale_s;
    logic signed [12:0] lines_m1;

    assign adv_px   = i_entry.advance[15:ADV_SHIFT];
    assign dy_px    = $signed({2'b00, i_entry.height})
                    - $signed({{2{i_entry.bearing_top[7]}}, i_entry.bearing_top});
    assign scale_s  = $signed({1'b0, i_cfg.scale_q8});
    assign lines_m1 = $signed({1'b0, i_line_count}) - 13'sd1;

    logic        [25:0] r_m_adv;
    logic signed [24:0] r_m_bl;
    logic signed [26:0] r_m_dy;
    logic        [23:0] r_m_w;
    logic        [23:0] r_m_h;
    logic signed [40:0] r_m_start;
    logic        [15:0] r_tex;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_m_adv   <= adv_px * i_cfg.scale_q8;
            r_m_bl    <= $signed(i_entry.bearing_left) * scale_s;
            r_m_dy    <= dy_px * scale_s;
            r_m_w     <= i_entry.width * i_cfg.scale_q8;
            r_m_h     <= i_entry.height * i_cfg.scale_q8;
            r_m_start <= lines_m1 * $signed({1'b0, i_pitch_scale});
            r_tex     <= i_entry.texture;
        end
    end

    // pen update stage
    logic signed [PEN_W-1:0] r_pen_x;
    logic signed [PEN_W-1:0] r_pen_y;
    logic signed [WW-1:0]    pen_x_w;
    logic signed [WW-1:0]    pen_y_w;
    logic signed [WW-1:0]    adv_pen;
    logic signed [PEN_W-1:0] adv_x;

    assign pen_x_w = WW'(r_pen_x);
    assign pen_y_w = WW'(r_pen_y);
    assign adv_pen = to_pen(WW'(r_m_adv));
    assign adv_x   = sat_pen(pen_x_w + adv_pen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
            r_pen_y <= '0;
        end else if (i_ctl.sum_en) begin
            case (i_ctl.op)
                OP_START: begin
                    r_pen_x <= '0;
                    r_pen_y <= sat_pen(to_pen(WW'(r_m_start)));
                end
                OP_NEWLINE: begin
                    r_pen_x <= '0;
                    r_pen_y <= sat_pen(pen_y_w - to_pen(WW'(i_pitch_scale)));
                end
                OP_TAB: begin
                    // space advance is rounded to pen format before the times four
                    r_pen_x <= sat_pen(pen_x_w + (adv_pen <<< TAB_SHIFT));
                end
                OP_SPACE, OP_GLYPH: begin
                    r_pen_x <= adv_x;
                end
                default: begin
                    r_pen_x <= r_pen_x;
                end
            endcase
        end
    end

    logic signed [WW-1:0] r_xs;
    logic signed [WW-1:0] r_ys;
    logic        [16:0]   r_w;
    logic        [16:0]   r_h;
    logic        [15:0]   r_tex_q;

    // corner sums use the pen before this glyph's advance
    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_xs    <= pen_x_w + to_pen(WW'(r_m_bl));
            r_ys    <= pen_y_w - to_pen(WW'(r_m_dy));
            r_w     <= 17'((25'(r_m_w) + 25'(HALF_Q8)) >> SCALE_FRAC);
            r_h     <= 17'((25'(r_m_h) + 25'(HALF_Q8)) >> SCALE_FRAC);
            r_tex_q <= r_tex;
        end
    end

    // output stage: round to pixels, add size and text position
    logic signed [WW-1:0] xp;
    logic signed [WW-1:0] yp;
    logic signed [OW-1:0] xo;
    logic signed [OW-1:0] yo;
    logic signed [OW-1:0] xr;
    logic signed [OW-1:0] yt;

    assign xp = rnd_shr(r_xs, FRAC_BITS);
    assign yp = rnd_shr(r_ys, FRAC_BITS);
    assign xo = OW'(xp) + OW'(i_cfg.offset_x);
    assign yo = OW'(yp) + OW'(i_cfg.offset_y);
    assign xr = xo + $signed(OW'(r_w));
    assign yt = yo + $signed(OW'(r_h));

    always_comb begin
        o_quad.left    = sat_px(xo);
        o_quad.bottom  = sat_px(yo);
        o_quad.right   = sat_px(xr);
        o_quad.top     = sat_px(yt);
        o_quad.texture = r_tex_q;
    end

endmodule

// File: test/testbench.sv
// Self-checking testbench for glyph_quad_layout_core: predicted glyph quads against the stream.
`timescale 1ns / 100ps

module testbench
    import gql_pkg::*;
();

    localparam logic [1:0] REQ_NOP     = 2'd3;   // ignored request kind
    localparam int         HOLD_CYCLES = 500;
    localparam int         CYCLE_LIMIT = 600000;

    // input item body, char_code in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [11:0] line_count;
        logic [15:0] texture;
        logic [7:0]  height;
        logic [7:0]  width;
        logic [7:0]  bearing_top;
        logic [7:0]  bearing_left;
        logic [15:0] advance;
        logic [7:0]  code;
    } t_text_req;

    typedef struct {
        logic [1:0] kind;
        t_text_req  body;
    } t_text_item;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    glyph_quad_layout_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    t_cfg       layout_cfg = CFG_RST;
    t_entry     glyph_mem [GLYPH_COUNT_DEF];
    longint     pen_x = 0;
    longint     pen_y = 0;
    t_quad      pending_quads [$];

    // stimulus state
    t_text_item text_items [$];
    t_text_item next_item;
    logic [7:0] loaded_codes [$];
    bit         loaded [GLYPH_COUNT_DEF];
    int         items_sent  = 0;
    int         items_taken = 0;
    bit         idle_on     = 1'b1;
    bit         hold_req    = 1'b0;
    bit         hold_done   = 1'b0;
    bit         in_fire     = 1'b0;
    int         in_gap      = 0;
    int         out_gap     = 0;
    int         hold_cnt    = 0;
    int         cycle_cnt   = 0;

    int errors = 0;
    int n_loads = 0, n_starts = 0, n_chars = 0, n_quads = 0, n_settings = 0;

    // divide by 2^sh, half away from zero
    function automatic longint round_half_away(longint v, int unsigned sh);
        longint mag;
        if (sh == 0) return v;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    // pixel count times scale, in pen format
    function automatic longint scale_px(longint px);
        longint q8;
        q8 = px * longint'(layout_cfg.scale_q8);
        if (FRAC_BITS_DEF >= SCALE_FRAC) return q8 <<< (FRAC_BITS_DEF - SCALE_FRAC);
        return round_half_away(q8, SCALE_FRAC - FRAC_BITS_DEF);
    endfunction

    function automatic longint clamp_pen(longint v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    function automatic logic [15:0] clamp_px(longint v);
        if (v < -64'sd32768) return 16'h8000;
        if (v > 64'sd32767) return 16'h7fff;
        return v[15:0];
    endfunction

    function automatic longint adv_px(t_entry e);
        return longint'(e.advance >> ADV_SHIFT);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_FONT_HEIGHT: layout_cfg.font_height = val[9:0];
            CFG_LINE_GAP:    layout_cfg.line_gap    = val[7:0];
            CFG_SCALE:       layout_cfg.scale_q8    = val;
            CFG_OFFSET_X:    layout_cfg.offset_x    = val;
            CFG_OFFSET_Y:    layout_cfg.offset_y    = val;
            default: ;
        endcase
    endfunction

    function automatic void lay_out_item(logic [1:0] kind, t_text_req req);
        longint pitch, bl, bt, gw, gh, xp, yp, w, h, ox, oy;
        t_entry ent;
        t_quad  q;
        pitch = longint'(layout_cfg.font_height) + longint'(layout_cfg.line_gap);
        case (kind)
            REQ_LOAD: begin
                glyph_mem[req.code] = {req.texture, req.height, req.width,
                                       req.bearing_top, req.bearing_left, req.advance};
                n_loads++;
            end
            REQ_START: begin
                pen_x = 0;
                pen_y = clamp_pen(scale_px((longint'(req.line_count) - 1) * pitch));
                n_starts++;
            end
            REQ_CHAR: begin
                n_chars++;
                if (req.code == CH_NEWLINE) begin
                    pen_x = 0;
                    pen_y = clamp_pen(pen_y - scale_px(pitch));
                end else if (req.code == CH_TAB) begin
                    pen_x = clamp_pen(pen_x + (scale_px(adv_px(glyph_mem[CH_SPACE])) <<< TAB_SHIFT));
                end else begin
                    ent = glyph_mem[req.code];
                    if (req.code != CH_SPACE) begin
                        bl = longint'($signed(ent.bearing_left));
                        bt = longint'($signed(ent.bearing_top));
                        gw = longint'(ent.width);
                        gh = longint'(ent.height);
                        ox = longint'($signed(layout_cfg.offset_x));
                        oy = longint'($signed(layout_cfg.offset_y));
                        xp = round_half_away(pen_x + scale_px(bl), FRAC_BITS_DEF);
                        yp = round_half_away(pen_y - scale_px(gh - bt), FRAC_BITS_DEF);
                        w  = round_half_away(gw * longint'(layout_cfg.scale_q8), SCALE_FRAC);
                        h  = round_half_away(gh * longint'(layout_cfg.scale_q8), SCALE_FRAC);
                        q.left    = clamp_px(xp + ox);
                        q.bottom  = clamp_px(yp + oy);
                        q.right   = clamp_px(xp + w + ox);
                        q.top     = clamp_px(yp + h + oy);
                        q.texture = ent.texture;
                        pending_quads = {pending_quads, q};
                    end
                    pen_x = clamp_pen(pen_x + scale_px(adv_px(ent)));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void field_check(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_quad(t_quad got);
        t_quad want;
        if (pending_quads.size() == 0) begin
            $error("quad with none expected: %h", got);
            errors++;
        end else begin
            want = pending_quads.pop_front();
            field_check("quad_left",    $signed(want.left),   $signed(got.left));
            field_check("quad_bottom",  $signed(want.bottom), $signed(got.bottom));
            field_check("quad_right",   $signed(want.right),  $signed(got.right));
            field_check("quad_top",     $signed(want.top),    $signed(got.top));
            field_check("quad_texture", want.texture,         got.texture);
            n_quads++;
        end
    endfunction

    // all handshakes seen in one place, in a fixed order
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                lay_out_item(s_axis_tuser, s_axis_tdata);
                items_taken <= items_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) check_quad(m_axis_tdata);
        end
    end

    // item driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && !in_fire)) begin
            if (in_gap != 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (text_items.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                in_gap <= $urandom_range(0, 13);
                s_axis_tvalid <= 1'b0;
            end else begin
                next_item = text_items.pop_front();
                s_axis_tuser  <= next_item.kind;
                s_axis_tdata  <= next_item.body;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // quad receiver: random stalls, plus one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
            end else if (out_gap != 0) begin
                out_gap <= out_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL glyph_quad_layout_core");
            $finish;
        end
    end

    function automatic t_text_req random_req();
        logic [95:0] raw;
        t_text_req   r;
        raw   = {$urandom, $urandom, $urandom};
        r     = raw[87:0];
        r.pad = '0;
        return r;
    endfunction

    task automatic queue_item(logic [1:0] kind, t_text_req body);
        t_text_item it;
        it.kind = kind;
        it.body = body;
        text_items = {text_items, it};
        items_sent++;
    endtask

    task automatic push_load(logic [7:0] code, logic [15:0] adv, logic [7:0] bl,
                             logic [7:0] bt, logic [7:0] w, logic [7:0] h, logic [15:0] tex);
        t_text_req r;
        r = random_req();
        r.code = code;
        r.advance = adv;
        r.bearing_left = bl;
        r.bearing_top = bt;
        r.width = w;
        r.height = h;
        r.texture = tex;
        queue_item(REQ_LOAD, r);
        if (!loaded[code]) begin
            loaded[code] = 1'b1;
            loaded_codes = {loaded_codes, code};
        end
    endtask

    task automatic push_start(logic [11:0] lines);
        t_text_req r;
        r = random_req();
        r.line_count = lines;
        queue_item(REQ_START, r);
    endtask

    task automatic push_char(logic [7:0] code);
        t_text_req r;
        r = random_req();
        r.code = code;
        queue_item(REQ_CHAR, r);
    endtask

    task automatic push_random_load();
        t_text_req r;
        r = random_req();
        if ($urandom_range(0, 3) != 0) r.advance = 16'($urandom_range(0, 2047));
        push_load(r.code, r.advance, r.bearing_left, r.bearing_top, r.width, r.height,
                  r.texture);
    endtask

    // a run of text: start, then characters drawn only from loaded entries
    task automatic push_text_run();
        int len, p;
        case ($urandom_range(0, 7))
            0:       push_start(12'($urandom));
            1:       push_start(12'd0);
            default: push_start(12'($urandom_range(1, 6)));
        endcase
        len = $urandom_range(3, 24);
        repeat (len) begin
            p = $urandom_range(0, 99);
            if (p < 8)       push_char(CH_NEWLINE);
            else if (p < 13) push_char(CH_TAB);
            else if (p < 25) push_char(CH_SPACE);
            else push_char(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]);
        end
    endtask

    task automatic run_phase(int n_items, bit idle);
        int start_cnt;
        idle_on = idle;
        start_cnt = items_sent;
        while (items_sent - start_cnt < n_items) begin
            case ($urandom_range(0, 19))
                0, 1:    push_random_load();
                2:       queue_item(REQ_NOP, random_req());
                default: push_text_run();
            endcase
        end
    endtask

    // block idle: every item taken, every quad back, pipeline empty
    task automatic settle();
        int waited;
        waited = 0;
        do @(negedge i_clk); while (items_taken != items_sent);
        while (pending_quads.size() != 0 && waited < 4000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_layout(logic [9:0] h, logic [7:0] g, logic [15:0] s,
                                  logic [15:0] ox, logic [15:0] oy);
        write_reg(CFG_FONT_HEIGHT, 16'(h));
        write_reg(CFG_LINE_GAP, 16'(g));
        write_reg(CFG_SCALE, s);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        n_settings++;
    endtask

    task automatic program_random_layout();
        logic [9:0]  h;
        logic [7:0]  g;
        logic [15:0] s, ox, oy;
        h  = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(8, 48));
        g  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        s  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(128, 768));
        ox = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
        oy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
        program_layout(h, g, s, ox, oy);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed text at reset settings; space entry first so tabs are legal
        push_load(CH_SPACE, 16'd512, 8'd0, 8'd0, 8'd0, 8'd0, 16'd7);
        push_load(8'd65, 16'd672, 8'd1, 8'd12, 8'd8, 8'd12, 16'h1234);
        push_load(8'd0, 16'hffff, 8'h80, 8'h7f, 8'hff, 8'hff, 16'hffff);   // extremes
        push_load(8'd255, 16'd0, 8'h7f, 8'h80, 8'd0, 8'd0, 16'd0);
        push_load(CH_NEWLINE, 16'd100, 8'd3, 8'd3, 8'd3, 8'd3, 16'd3);
        push_start(12'd3);
        push_char(8'd65);
        push_char(CH_SPACE);
        push_char(CH_TAB);
        push_char(8'd0);
        push_char(8'd255);
        push_char(CH_NEWLINE);
        push_char(8'd65);
        queue_item(REQ_NOP, random_req());
        push_start(12'd0);                      // pen one line below the origin
        push_char(8'd65);
        push_start(12'hfff);
        push_char(8'd0);
        push_char(CH_NEWLINE);
        push_load(8'd200, 16'd320, 8'hf6, 8'hfb, 8'd17, 8'd9, 16'h8001);
        push_char(8'd200);
        settle();

        program_layout(10'd1023, 8'd255, 16'hffff, 16'h7fff, 16'h8000);
        run_phase(200, 1'b1);
        settle();

        // scale of zero, and the quad output held off while items keep coming
        program_layout(10'd0, 8'd0, 16'd0, 16'h8000, 16'h7fff);
        hold_req = 1'b1;
        run_phase(200, 1'b1);
        settle();

        program_layout(10'd16, 8'd4, 16'd1, 16'd0, 16'd0);
        run_phase(150, 1'b0);
        settle();

        for (int k = 0; k < 6; k++) begin
            program_random_layout();
            run_phase(200, k % 3 != 2);
            settle();
        end

        program_random_layout();
        run_phase(200, 1'b0);
        settle();

        if (pending_quads.size() != 0) begin
            $error("%0d expected quads never arrived", pending_quads.size());
            errors++;
        end
        $display("%0d items taken: %0d glyph loads, %0d starts, %0d characters",
                 items_taken, n_loads, n_starts, n_chars);
        $display("%0d quads compared over %0d register settings, %0d mismatches",
                 n_quads, n_settings + 1, errors);
        if (errors == 0) begin
            $display("PASS glyph_quad_layout_core");
        end else begin
            $display("FAIL glyph_quad_layout_core");
        end
        $finish;
    end

endmodule

// File: glyph_quad_layout_core.f
+incdir+rtl/core
rtl/core/gql_pkg.sv
rtl/core/gql_ram.sv
rtl/core/gql_pen_unit.sv
rtl/core/glyph_quad_layout_core.sv
test/testbench.sv
